@@ rtl/usr_pkg.sv @@
// Shared types, constants and the byte classifier for the unit string recognizer.
// No dependencies; usr_classify, usr_queue, usr_parse and the top level use this package.
package usr_pkg;

	localparam int MAX_DEPTH   = 16;
	localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7a;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5a;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_CARET  = 8'h5e;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_UNDER  = 8'h5f;

	typedef enum logic [3:0] {
		CC_DIGIT,
		CC_EXP,
		CC_ALPHA,
		CC_PCT,
		CC_UNDER,
		CC_BLANK,
		CC_STAR,
		CC_SLASH,
		CC_LPAR,
		CC_RPAR,
		CC_CARET,
		CC_SIGN,
		CC_DOT,
		CC_OTHER
	} char_class_t;

	typedef enum logic [3:0] {
		PH_EXPECT_ATOM,
		PH_SEP_SPACE,
		PH_NUM_INT,
		PH_NUM_DOT0,
		PH_NUM_FRAC,
		PH_NUM_E,
		PH_NUM_ESIGN,
		PH_NUM_EDIG,
		PH_IDENT,
		PH_ATOM_END,
		PH_ATOM_STAR,
		PH_EXP_OP,
		PH_EXP_SIGN,
		PH_EXP_DIG
	} phase_t;

	typedef struct packed {
		char_class_t cls;
		logic        no_char;
		logic        last;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t data;
	} push_t;

	typedef struct packed {
		logic   valid;
		entry_t data;
	} head_t;

	// e and E sit inside the letter ranges; the first matching arm wins
	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t r;
		case (c) inside
			[CH_0:CH_9]:             r = CC_DIGIT;
			CH_LO_E, CH_UP_E:        r = CC_EXP;
			[CH_LO_A:CH_LO_Z],
			[CH_UP_A:CH_UP_Z]:       r = CC_ALPHA;
			CH_PCT:                  r = CC_PCT;
			CH_UNDER:                r = CC_UNDER;
			CH_SPACE, CH_TAB:        r = CC_BLANK;
			CH_STAR:                 r = CC_STAR;
			CH_SLASH:                r = CC_SLASH;
			CH_LPAR:                 r = CC_LPAR;
			CH_RPAR:                 r = CC_RPAR;
			CH_CARET:                r = CC_CARET;
			CH_PLUS, CH_MINUS:       r = CC_SIGN;
			CH_DOT:                  r = CC_DOT;
			default:                 r = CC_OTHER;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/usr_in_if.sv @@
// Request channel carrying one byte of a unit string.
// Depends on nothing.
interface usr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       no_char;
	logic       last;

	modport source (output valid, output ch, output no_char, output last, input ready);
	modport sink   (input valid, input ch, input no_char, input last, output ready);
endinterface

@@ rtl/usr_out_if.sv @@
// Result channel: verdict for one complete unit string.
// Depends on nothing.
interface usr_out_if;
	logic valid;
	logic ready;
	logic well_formed;
	logic depth_overflow;

	modport source (output valid, output well_formed, output depth_overflow, input ready);
	modport sink   (input valid, input well_formed, input depth_overflow, output ready);
endinterface

@@ rtl/usr_classify.sv @@
// Front end: takes byte requests and pushes their character class into the queue.
// Depends on usr_pkg and usr_in_if.
module usr_classify (
	usr_in_if.sink        item,
	input  logic          full,
	output usr_pkg::push_t push
);

	assign item.ready = !full;

	always_comb begin
		push.push         = item.valid && !full;
		push.data.cls     = usr_pkg::classify(item.ch);
		push.data.no_char = item.no_char;
		push.data.last    = item.last;
	end

endmodule

@@ rtl/usr_queue.sv @@
// Short queue between the classifier and the parser.
// Depends on usr_pkg.
module usr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  usr_pkg::push_t  push,
	input  logic            pop,
	output logic            full,
	output usr_pkg::head_t  head
);

	usr_pkg::entry_t                   mem_q [usr_pkg::QUEUE_DEPTH];
	logic [usr_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [usr_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [usr_pkg::QUEUE_PTR_W:0]     count_q;
	logic                              do_pop;

	assign full       = count_q == (usr_pkg::QUEUE_PTR_W + 1)'(usr_pkg::QUEUE_DEPTH);
	assign head.valid = count_q != '0;
	assign head.data  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/usr_parse.sv @@
// Back end: grammar state machine with bracket depth counter and result register.
// Depends on usr_pkg and usr_out_if.
module usr_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  usr_pkg::head_t head,
	output logic           pop,
	usr_out_if.source      result
);

	typedef struct packed {
		usr_pkg::phase_t ph;
		logic            fail;
		logic            ovf;
		logic            inc;
		logic            dec;
	} act_t;

	usr_pkg::phase_t              phase_q, phase_d;
	logic [usr_pkg::DEPTH_W-1:0]  depth_q, depth_d;
	logic                         failed_q, failed_d;
	logic                         ovf_q, ovf_d;
	logic                         out_valid_q;
	logic                         wf_q;
	logic                         dov_q;

	usr_pkg::char_class_t         cls;
	logic                         take;
	logic                         is_digit, is_alpha, is_sign, is_blank;
	act_t                         a_close, a_power, a_start, a_atom, a_expect, act;
	logic                         accepts;
	logic                         emit;

	assign cls      = head.data.cls;
	assign is_digit = cls == usr_pkg::CC_DIGIT;
	assign is_alpha = (cls == usr_pkg::CC_ALPHA) || (cls == usr_pkg::CC_EXP);
	assign is_sign  = cls == usr_pkg::CC_SIGN;
	assign is_blank = cls == usr_pkg::CC_BLANK;

	// Output side: a string end waits for a free result slot.
	always_comb begin
		pop  = head.valid && (!head.data.last || !out_valid_q || result.ready);
		emit = pop && head.data.last;
		take = pop && !head.data.no_char && !failed_q;
	end

	// Shared sub-actions of the grammar.
	always_comb begin
		a_close = '{ph: usr_pkg::PH_ATOM_END, fail: depth_q == '0, ovf: 1'b0,
			inc: 1'b0, dec: depth_q != '0};

		a_power = '{ph: phase_q, fail: 1'b0, ovf: 1'b0, inc: 1'b0, dec: 1'b0};
		case (cls)
			usr_pkg::CC_BLANK:                    a_power.ph = usr_pkg::PH_SEP_SPACE;
			usr_pkg::CC_STAR, usr_pkg::CC_SLASH:  a_power.ph = usr_pkg::PH_EXPECT_ATOM;
			usr_pkg::CC_RPAR:                     a_power = a_close;
			default:                              a_power.fail = 1'b1;
		endcase

		a_start = '{ph: phase_q, fail: 1'b0, ovf: 1'b0, inc: 1'b0, dec: 1'b0};
		if (cls == usr_pkg::CC_LPAR) begin
			if (depth_q >= usr_pkg::DEPTH_W'(usr_pkg::MAX_DEPTH)) begin
				a_start.fail = 1'b1;
				a_start.ovf  = 1'b1;
			end else begin
				a_start.inc = 1'b1;
				a_start.ph  = usr_pkg::PH_EXPECT_ATOM;
			end
		end else if (is_digit) begin
			a_start.ph = usr_pkg::PH_NUM_INT;
		end else if (cls == usr_pkg::CC_DOT) begin
			a_start.ph = usr_pkg::PH_NUM_DOT0;
		end else if (is_alpha || cls == usr_pkg::CC_PCT) begin
			a_start.ph = usr_pkg::PH_IDENT;
		end else begin
			a_start.fail = 1'b1;
		end

		a_atom = '{ph: phase_q, fail: 1'b0, ovf: 1'b0, inc: 1'b0, dec: 1'b0};
		case (cls)
			usr_pkg::CC_CARET: a_atom.ph = usr_pkg::PH_EXP_OP;
			usr_pkg::CC_STAR:  a_atom.ph = usr_pkg::PH_ATOM_STAR;
			usr_pkg::CC_SIGN:  a_atom.ph = usr_pkg::PH_EXP_SIGN;
			usr_pkg::CC_DIGIT: a_atom.ph = usr_pkg::PH_EXP_DIG;
			default:           a_atom = a_power;
		endcase

		if (is_blank) begin
			a_expect = '{ph: usr_pkg::PH_EXPECT_ATOM, fail: 1'b0, ovf: 1'b0,
				inc: 1'b0, dec: 1'b0};
		end else begin
			a_expect = a_start;
		end
	end

	// Next state.
	always_comb begin
		act = '{ph: phase_q, fail: 1'b0, ovf: 1'b0, inc: 1'b0, dec: 1'b0};
		unique case (phase_q)
			usr_pkg::PH_EXPECT_ATOM: act = a_expect;
			usr_pkg::PH_SEP_SPACE: begin
				if (is_blank) begin
					act.ph = phase_q;
				end else if (cls == usr_pkg::CC_STAR || cls == usr_pkg::CC_SLASH) begin
					act.ph = usr_pkg::PH_EXPECT_ATOM;
				end else if (cls == usr_pkg::CC_RPAR) begin
					act = a_close;
				end else begin
					act = a_start;
				end
			end
			usr_pkg::PH_NUM_INT: begin
				if (is_digit) begin
					act.ph = phase_q;
				end else if (cls == usr_pkg::CC_DOT) begin
					act.ph = usr_pkg::PH_NUM_FRAC;
				end else if (cls == usr_pkg::CC_EXP) begin
					act.ph = usr_pkg::PH_NUM_E;
				end else begin
					act = a_atom;
				end
			end
			usr_pkg::PH_NUM_DOT0: begin
				if (is_digit) act.ph = usr_pkg::PH_NUM_FRAC;
				else          act.fail = 1'b1;
			end
			usr_pkg::PH_NUM_FRAC: begin
				if (is_digit) begin
					act.ph = phase_q;
				end else if (cls == usr_pkg::CC_EXP) begin
					act.ph = usr_pkg::PH_NUM_E;
				end else begin
					act = a_atom;
				end
			end
			usr_pkg::PH_NUM_E: begin
				if (is_sign)       act.ph = usr_pkg::PH_NUM_ESIGN;
				else if (is_digit) act.ph = usr_pkg::PH_NUM_EDIG;
				else               act.fail = 1'b1;
			end
			usr_pkg::PH_NUM_ESIGN: begin
				if (is_digit) act.ph = usr_pkg::PH_NUM_EDIG;
				else          act.fail = 1'b1;
			end
			usr_pkg::PH_NUM_EDIG: begin
				if (!is_digit) act = a_atom;
			end
			usr_pkg::PH_IDENT: begin
				if (!(is_alpha || cls == usr_pkg::CC_UNDER || cls == usr_pkg::CC_PCT)) begin
					act = a_atom;
				end
			end
			usr_pkg::PH_ATOM_END: act = a_atom;
			usr_pkg::PH_ATOM_STAR: begin
				if (cls == usr_pkg::CC_STAR) act.ph = usr_pkg::PH_EXP_OP;
				else                         act = a_expect;
			end
			usr_pkg::PH_EXP_OP: begin
				if (is_sign)       act.ph = usr_pkg::PH_EXP_SIGN;
				else if (is_digit) act.ph = usr_pkg::PH_EXP_DIG;
				else               act.fail = 1'b1;
			end
			usr_pkg::PH_EXP_SIGN: begin
				if (is_digit) act.ph = usr_pkg::PH_EXP_DIG;
				else          act.fail = 1'b1;
			end
			usr_pkg::PH_EXP_DIG: begin
				if (!is_digit) act = a_power;
			end
			default: act.fail = 1'b1;
		endcase

		phase_d  = phase_q;
		depth_d  = depth_q;
		failed_d = failed_q;
		ovf_d    = ovf_q;
		if (take) begin
			phase_d  = act.ph;
			failed_d = act.fail;
			ovf_d    = ovf_q | act.ovf;
			if (act.inc) begin
				depth_d = depth_q + 1'b1;
			end else if (act.dec) begin
				depth_d = depth_q - 1'b1;
			end
		end
	end

	// Verdict outputs from the post-byte state.
	always_comb begin
		case (phase_d)
			usr_pkg::PH_NUM_INT, usr_pkg::PH_NUM_FRAC, usr_pkg::PH_NUM_EDIG,
			usr_pkg::PH_IDENT, usr_pkg::PH_ATOM_END, usr_pkg::PH_EXP_DIG,
			usr_pkg::PH_SEP_SPACE: accepts = 1'b1;
			default:               accepts = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= usr_pkg::PH_EXPECT_ATOM;
			depth_q  <= '0;
			failed_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (emit) begin
			phase_q  <= usr_pkg::PH_EXPECT_ATOM;
			depth_q  <= '0;
			failed_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			depth_q  <= depth_d;
			failed_q <= failed_d;
			ovf_q    <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			wf_q  <= !failed_d && accepts && (depth_d == '0);
			dov_q <= ovf_d;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.well_formed    = wf_q;
	assign result.depth_overflow = dov_q;

endmodule

@@ rtl/units_string_recognizer.sv @@
// Top level of the unit string recognizer: classifier, queue and parser.
// Depends on usr_pkg, usr_in_if, usr_out_if, usr_classify, usr_queue, usr_parse.
//
// Checks unit strings (products of powers, brackets nested up to MAX_DEPTH)
// fed one byte per request; the request flagged last yields one result with
// well_formed and depth_overflow, and the parser then starts over for the next
// string. Throughput is one byte per clock while nothing stalls, set by the
// phase and depth update in the parser. A byte is written into the two-entry
// queue and the verdict is registered, so the result is valid once the last
// byte has passed through the queue entry and the result register. A result
// that is not taken holds back only the next string's last byte; the bytes
// before it keep flowing, and input stalls once the queue fills.
module units_string_recognizer (
	input  logic       clk,
	input  logic       arst_n,
	usr_in_if.sink     item,
	usr_out_if.source  result
);

	usr_pkg::push_t push;
	usr_pkg::head_t head;
	logic           full;
	logic           pop;

	usr_classify u_classify (
		.item (item),
		.full (full),
		.push (push)
	);

	usr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (full),
		.head   (head)
	);

	usr_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule
